[rtl/core/deadline_sorted_task_queue_macros.svh]
// Assertion macros for the deadline sorted task queue
`ifndef DEADLINE_SORTED_TASK_QUEUE_MACROS_SVH
`define DEADLINE_SORTED_TASK_QUEUE_MACROS_SVH
// Same-cycle implication, checked outside reset
`define DSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsq assertion failed");
// Next-cycle implication, checked outside reset
`define DSQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsq assertion failed");
`endif

[rtl/core/dsq_pkg.sv]
// Shared types and constants of the deadline sorted task queue
package dsq_pkg;
  localparam int TASKS = 8;
  localparam int TASK_W = $clog2(TASKS);
  localparam int CNT_W = $clog2(TASKS + 1);
  localparam logic [31:0] SUSPENDED = 32'hFFFF_FFFF;
  localparam logic [31:0] TIME_MASK = 32'h00FF_FFFF;
  localparam logic [7:0] NEXT_EPOCH = 8'h01;
  localparam logic [7:0] TOP_SUSPENDED = 8'hFF;

  typedef enum logic [2:0] {
    FN_POLL = 3'd0,
    FN_CREATE = 3'd1,
    FN_SUSPEND = 3'd2,
    FN_RESUME = 3'd3,
    FN_ADD_PERIOD = 3'd4,
    FN_ADD_DELAY = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [TASK_W-1:0] task_id;
  } slot_t;

  typedef struct packed {
    cell_op_t op;
    logic [31:0] value;
    logic [TASK_W-1:0] task_id;
  } cell_ctl_t;
endpackage

[rtl/core/dsq_cell.sv]
// One sorted slot of the queue: removal shifts left, insertion shifts right
module dsq_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dsq_pkg::TASK_W-1:0]     init_task,
  input  logic                           is_last,
  input  dsq_pkg::cell_ctl_t             ctl,
  input  dsq_pkg::slot_t                 left_slot,
  input  dsq_pkg::slot_t                 right_slot,
  input  logic                           found_in,
  input  logic                           after_in,
  output dsq_pkg::slot_t                 slot,
  output logic                           found_out,
  output logic                           after_out
);
  dsq_pkg::slot_t slot_r, slot_nxt;
  logic found, here;

  assign found = found_in || (slot_r.task_id == ctl.task_id);
  assign here = is_last || (slot_r.deadline > ctl.value);
  assign found_out = found;
  assign after_out = after_in || here;
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    unique case (ctl.op)
      dsq_pkg::OP_REMOVE: begin
        if (found && !is_last) slot_nxt = right_slot;
      end
      dsq_pkg::OP_INSERT: begin
        if (after_in) begin
          slot_nxt = left_slot;
        end else if (here) begin
          slot_nxt.deadline = ctl.value;
          slot_nxt.task_id = ctl.task_id;
        end
      end
      dsq_pkg::OP_CLEAR: begin
        if (slot_r.deadline[31:24] == dsq_pkg::NEXT_EPOCH)
          slot_nxt.deadline = slot_r.deadline & dsq_pkg::TIME_MASK;
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.deadline <= dsq_pkg::SUSPENDED;
      slot_r.task_id <= init_task;
    end else begin
      slot_r <= slot_nxt;
    end
  end
endmodule

[rtl/core/deadline_sorted_task_queue.sv]
// Top level of the deadline sorted task queue: control and the row of slot cells
//
// channel | dir | tvalid/tready | payload
// in_     | in  | handshake     | tuser: func[2:0]; tdata: task_req, amount, now_tick
// out_    | out | handshake     | tdata: due, due_task, waiting_count
//
// A poll goes from accept straight to report; a re-sorting operation closes the
// gap along the cell chain, opens it at the new place, then registers the result.
// A no-change operation goes straight to report. Synchronous active-low reset
// leaves every slot suspended, slot i holding task i. While a result waits, one
// more transaction is taken; its report then holds until the output drains.
`include "deadline_sorted_task_queue_macros.svh"
module deadline_sorted_task_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // task_req[2:0], amount[34:3], now_tick[66:35], zero pad
  input  logic [2:0]  in_tuser,  // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // due[0], due_task[3:1], waiting_count[7:4]
);
  localparam int N = dsq_pkg::TASKS;

  dsq_pkg::state_t state_r, state_nxt;
  dsq_pkg::cell_ctl_t ctl;
  dsq_pkg::slot_t slots [N];
  dsq_pkg::slot_t lefts [N];
  dsq_pkg::slot_t rights [N];
  logic [N:0] found_c, after_c;

  logic [31:0] value_r, value_nxt;
  logic [dsq_pkg::TASK_W-1:0] task_r, task_nxt;
  logic poll_r, poll_nxt;
  logic [23:0] cur_r, cur_nxt;
  logic [7:0] seen_epoch_r, seen_epoch_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  logic [2:0] func;
  logic [dsq_pkg::TASK_W-1:0] task_req;
  logic [31:0] amount, now_tick, old_dl;
  logic [23:0] t;
  logic [dsq_pkg::CNT_W-1:0] count;
  logic accept;

  assign func = in_tuser;
  assign task_req = in_tdata[dsq_pkg::TASK_W-1:0];
  assign amount = in_tdata[34:3];
  assign now_tick = in_tdata[66:35];
  assign t = now_tick[23:0];
  assign in_tready = (state_r == dsq_pkg::ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign found_c[0] = 1'b0;
  assign after_c[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
    end else begin : g_mid
      assign lefts[i] = slots[i-1];
    end
    if (i == N - 1) begin : g_end
      assign rights[i] = slots[i];
    end else begin : g_inner
      assign rights[i] = slots[i+1];
    end
    dsq_cell u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .init_task(dsq_pkg::TASK_W'(i)),
      .is_last(i == N - 1),
      .ctl(ctl),
      .left_slot(lefts[i]),
      .right_slot(rights[i]),
      .found_in(found_c[i]),
      .after_in(after_c[i]),
      .slot(slots[i]),
      .found_out(found_c[i+1]),
      .after_out(after_c[i+1])
    );
  end

  // Waiting count and the task's current deadline
  always_comb begin
    count = '0;
    old_dl = '0;
    for (int k = 0; k < N; k++) begin
      if (slots[k].deadline[31:24] != 8'h00) count = count + 1'b1;
      if (slots[k].task_id == task_req) old_dl = old_dl | slots[k].deadline;
    end
  end

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    task_nxt = task_r;
    poll_nxt = poll_r;
    cur_nxt = cur_r;
    seen_epoch_nxt = seen_epoch_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    ctl.op = dsq_pkg::OP_HOLD;
    ctl.value = value_r;
    ctl.task_id = task_r;
    unique case (state_r)
      dsq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dsq_pkg::ST_REPORT;
          poll_nxt = (func == dsq_pkg::FN_POLL);
          task_nxt = task_req;
          ctl.task_id = task_req;
          if (func == dsq_pkg::FN_POLL) begin
            cur_nxt = t;
            if (seen_epoch_r != now_tick[31:24]) begin
              if (count >= dsq_pkg::CNT_W'(N)) begin
                ctl.op = dsq_pkg::OP_CLEAR;
                seen_epoch_nxt = now_tick[31:24];
              end else begin
                cur_nxt = dsq_pkg::TIME_MASK[23:0];
              end
            end
          end else if ({1'b0, task_req} < (dsq_pkg::TASK_W + 1)'(N)) begin
            priority case (func)
              dsq_pkg::FN_CREATE: begin
                value_nxt = amount;
                ctl.op = dsq_pkg::OP_REMOVE;
              end
              dsq_pkg::FN_SUSPEND: begin
                value_nxt = dsq_pkg::SUSPENDED;
                if (old_dl[31:24] != dsq_pkg::TOP_SUSPENDED) ctl.op = dsq_pkg::OP_REMOVE;
              end
              dsq_pkg::FN_RESUME: begin
                value_nxt = {8'h00, t};
                if (old_dl[31:24] == dsq_pkg::TOP_SUSPENDED) ctl.op = dsq_pkg::OP_REMOVE;
              end
              dsq_pkg::FN_ADD_PERIOD: begin
                value_nxt = old_dl + amount;
                ctl.op = dsq_pkg::OP_REMOVE;
              end
              dsq_pkg::FN_ADD_DELAY: begin
                value_nxt = {8'h00, t} + amount;
                ctl.op = dsq_pkg::OP_REMOVE;
              end
              default: ctl.op = dsq_pkg::OP_HOLD;
            endcase
            if (ctl.op == dsq_pkg::OP_REMOVE) state_nxt = dsq_pkg::ST_INSERT;
          end
        end
      end
      dsq_pkg::ST_INSERT: begin
        ctl.op = dsq_pkg::OP_INSERT;
        state_nxt = dsq_pkg::ST_REPORT;
      end
      dsq_pkg::ST_REPORT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {count, slots[0].task_id,
                          poll_r && ({8'h00, cur_r} >= slots[0].deadline)};
          state_nxt = dsq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dsq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsq_pkg::ST_IDLE;
      seen_epoch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_epoch_r <= seen_epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    task_r <= task_nxt;
    poll_r <= poll_nxt;
    cur_r <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  `DSQ_ASSERT_NXT(a_insert_then_report, state_r == dsq_pkg::ST_INSERT, state_r == dsq_pkg::ST_REPORT)
  `DSQ_ASSERT_IMP(a_head_sorted, state_r == dsq_pkg::ST_IDLE, slots[0].deadline <= slots[1].deadline)
  `DSQ_ASSERT_IMP(a_count_bound, out_valid_r, out_data_r[7:4] <= 4'(N))
endmodule
